>>> rtl/core/lsp_pkg.sv
`default_nettype none

package lsp_pkg;

  // Table geometry
  localparam int MAX_LINES = 4096;
  localparam int ADDR_W    = $clog2(MAX_LINES);
  localparam int LINE_W    = $clog2(MAX_LINES + 1);
  localparam int OFF_W     = 32;

  // Newline bytes
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] LEAD2  = 8'hC2;
  localparam logic [7:0] LEAD3  = 8'hE2;
  localparam logic [7:0] MID3   = 8'h80;
  localparam logic [7:0] NEL_LO = 8'h85;
  localparam logic [7:0] LS_LO  = 8'hA8;
  localparam logic [7:0] PS_LO  = 8'hA9;

  // newline_mode bits
  localparam int MODE_CR_BIT   = 0;
  localparam int MODE_LF_BIT   = 1;
  localparam int MODE_CRLF_BIT = 2;
  localparam int MODE_UNI_BIT  = 3;
  localparam logic [3:0] MODE_DEFAULT = 4'h7;

  // Command codes
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_END   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  // Register map
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_MODE_IDX = 3'd0;

  // Partial newline match held between bytes
  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_CR,
    PEND_C2,
    PEND_E2,
    PEND_E280
  } pend_t;

  // Scanner verdict for one byte
  typedef struct packed {
    logic  rec_p;    // line starts at the byte's own offset (lone CR settled)
    logic  rec_p1;   // line starts after the byte
    pend_t pend;
  } scan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REC2,
    S_SEARCH,
    S_CMP
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/lsp_ram.sv
`default_nettype none

module lsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lsp_scan.sv
`default_nettype none

module lsp_scan import lsp_pkg::*; (
  input  wire [7:0] data_byte,
  input  wire pend_t pend,
  input  wire [3:0] mode,
  output scan_t     verdict
);

  function automatic scan_t fresh(input logic [7:0] b, input logic [3:0] m);
    scan_t r;
    r = '{rec_p: 1'b0, rec_p1: 1'b0, pend: PEND_NONE};
    if (b == CH_CR) begin
      if (m[MODE_CRLF_BIT]) begin
        r.pend = PEND_CR;
      end else if (m[MODE_CR_BIT]) begin
        r.rec_p1 = 1'b1;
      end
    end else if (b == CH_LF) begin
      r.rec_p1 = m[MODE_LF_BIT];
    end else if (m[MODE_UNI_BIT] && b == LEAD2) begin
      r.pend = PEND_C2;
    end else if (m[MODE_UNI_BIT] && b == LEAD3) begin
      r.pend = PEND_E2;
    end
    return r;
  endfunction

  logic uni;
  assign uni = mode[MODE_UNI_BIT];

  always_comb begin
    verdict = fresh(data_byte, mode);
    unique case (pend)
      PEND_NONE: ;
      PEND_CR: begin
        if (data_byte == CH_LF && mode[MODE_CRLF_BIT]) begin
          verdict = '{rec_p: 1'b0, rec_p1: 1'b1, pend: PEND_NONE};
        end else begin
          // lone CR settles at the CR's successor offset, then rescan
          verdict.rec_p = mode[MODE_CR_BIT];
        end
      end
      PEND_C2: begin
        if (uni && data_byte == NEL_LO) begin
          verdict = '{rec_p: 1'b0, rec_p1: 1'b1, pend: PEND_NONE};
        end
      end
      PEND_E2: begin
        if (uni && data_byte == MID3) begin
          verdict = '{rec_p: 1'b0, rec_p1: 1'b0, pend: PEND_E280};
        end
      end
      PEND_E280: begin
        if (uni && (data_byte == LS_LO || data_byte == PS_LO)) begin
          verdict = '{rec_p: 1'b0, rec_p1: 1'b1, pend: PEND_NONE};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/line_index_and_position_lookup.sv
`default_nettype none
// Channel     Handshake              Payload
// command     start / busy           func, data_byte, query_pos
// result      done (1-cycle strobe)  line, column, status
// config      APB psel/penable/...   newline_mode at byte address 0
//
// A source byte or end transaction leaves the block idle, ready for another
// command; a byte that settles a lone CR and also ends a line on its own
// passes through S_REC2 (two table writes on the single RAM write port).
// Each binary-search step of a query is one RAM read plus one compare.
// Early or overflow queries answer the cycle after acceptance.
// rst is synchronous; no clearing pass, entry 0 is never read from the RAM.
// Results are strobed for one cycle; the receiver cannot stall them.

module line_index_and_position_lookup import lsp_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  // command
  input  wire                start,
  output logic               busy,
  input  wire [1:0]          func,
  input  wire [7:0]          data_byte,
  input  wire [31:0]         query_pos,
  // result
  output logic               done,
  output logic [LINE_W-1:0]  line,
  output logic [31:0]        column,
  output logic [1:0]         status,
  // config
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [PADDR_W-1:0]  paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_t state, state_next;

  // Scan state
  logic [3:0]        newline_mode;
  logic [LINE_W-1:0] lines_recorded, lines_recorded_next;
  logic [OFF_W-1:0]  bytes_seen, bytes_seen_next;
  pend_t             pend, pend_next;
  logic              table_overflow, table_overflow_next;
  logic              source_ended, source_ended_next;
  logic [OFF_W-1:0]  rec_off, rec_off_next;   // deferred second line start

  // Search state
  logic [LINE_W-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic [OFF_W-1:0]  lo_val, lo_val_next, pos, pos_next;

  // Result registers
  logic              done_next;
  logic [LINE_W-1:0] line_next;
  logic [31:0]       column_next;
  logic [1:0]        status_next;

  logic [3:0]        eff_mode;
  scan_t             verdict;
  logic              accept, cfg_wr;

  logic              rec_req;
  logic [OFF_W-1:0]  rec_val;
  logic              ram_we, ram_re;
  logic [OFF_W-1:0]  ram_rdata;
  logic [LINE_W-1:0] probe;
  logic [OFF_W:0]    col_wide;

  assign eff_mode = (newline_mode == 4'd0) ? MODE_DEFAULT : newline_mode;
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_MODE_IDX[PADDR_W-1:2]) begin
      prdata = {28'd0, newline_mode};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newline_mode <= '0;
    end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_MODE_IDX[PADDR_W-1:2]) begin
      newline_mode <= pwdata[3:0];
    end
  end

  lsp_scan u_scan (
    .data_byte (data_byte),
    .pend      (pend),
    .mode      (eff_mode),
    .verdict   (verdict)
  );

  // Midpoint of the live search window and the final column
  assign probe    = lo + ((hi - lo) >> 1);
  assign col_wide = {1'b0, pos} - {1'b0, lo_val} + {{OFF_W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next          = state;
    lines_recorded_next = lines_recorded;
    bytes_seen_next     = bytes_seen;
    pend_next           = pend;
    table_overflow_next = table_overflow;
    source_ended_next   = source_ended;
    rec_off_next        = rec_off;
    lo_next             = lo;
    hi_next             = hi;
    mid_next            = mid;
    lo_val_next         = lo_val;
    pos_next            = pos;
    done_next           = 1'b0;
    line_next           = line;
    column_next         = column;
    status_next         = status;
    rec_req             = 1'b0;
    rec_val             = '0;
    ram_re              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_BYTE: begin
              if (!source_ended) begin
                if (table_overflow || bytes_seen == {OFF_W{1'b1}}) begin
                  table_overflow_next = 1'b1;
                end else begin
                  rec_req         = verdict.rec_p || verdict.rec_p1;
                  rec_val         = verdict.rec_p ? bytes_seen : bytes_seen + 1'b1;
                  pend_next       = verdict.pend;
                  bytes_seen_next = bytes_seen + 1'b1;
                  if (verdict.rec_p && verdict.rec_p1) begin
                    rec_off_next = bytes_seen + 1'b1;
                    state_next   = S_REC2;
                  end
                end
              end
            end
            FUNC_END: begin
              if (!source_ended) begin
                rec_req           = (pend == PEND_CR) && eff_mode[MODE_CR_BIT];
                rec_val           = bytes_seen;
                pend_next         = PEND_NONE;
                source_ended_next = 1'b1;
              end
            end
            FUNC_QUERY: begin
              if (!source_ended || table_overflow) begin
                done_next   = 1'b1;
                line_next   = LINE_W'(1);
                column_next = 32'd1;
                status_next = source_ended ? ST_OVF : ST_EARLY;
              end else begin
                pos_next    = (query_pos > bytes_seen) ? bytes_seen : query_pos;
                lo_next     = '0;
                hi_next     = lines_recorded;
                lo_val_next = '0;
                state_next  = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_REC2: begin
        rec_req    = 1'b1;
        rec_val    = rec_off;
        state_next = S_IDLE;
      end
      S_SEARCH: begin
        if (lo + 1'b1 < hi) begin
          ram_re     = 1'b1;
          mid_next   = probe;
          state_next = S_CMP;
        end else begin
          done_next   = 1'b1;
          line_next   = lo + 1'b1;
          column_next = col_wide[OFF_W] ? 32'hFFFF_FFFF : col_wide[OFF_W-1:0];
          status_next = ST_OK;
          state_next  = S_IDLE;
        end
      end
      S_CMP: begin
        if (ram_rdata <= pos) begin
          lo_next     = mid;
          lo_val_next = ram_rdata;
        end else begin
          hi_next = mid;
        end
        state_next = S_SEARCH;
      end
      default: state_next = S_IDLE;
    endcase

    // Append a line start, or flag overflow when the table is full
    ram_we = 1'b0;
    if (rec_req) begin
      if (lines_recorded == LINE_W'(MAX_LINES)) begin
        table_overflow_next = 1'b1;
      end else begin
        ram_we              = 1'b1;
        lines_recorded_next = lines_recorded + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_recorded <= LINE_W'(1);
      bytes_seen     <= '0;
      pend           <= PEND_NONE;
      table_overflow <= 1'b0;
      source_ended   <= 1'b0;
      done           <= 1'b0;
    end else begin
      lines_recorded <= lines_recorded_next;
      bytes_seen     <= bytes_seen_next;
      pend           <= pend_next;
      table_overflow <= table_overflow_next;
      source_ended   <= source_ended_next;
      done           <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rec_off <= rec_off_next;
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    lo_val  <= lo_val_next;
    pos     <= pos_next;
    line    <= line_next;
    column  <= column_next;
    status  <= status_next;
  end

  lsp_ram #(
    .WIDTH (OFF_W),
    .DEPTH (MAX_LINES)
  ) u_starts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lines_recorded[ADDR_W-1:0]),
    .wdata (rec_val),
    .re    (ram_re),
    .raddr (probe[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // A compare step always follows a read issued by the search step
  assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_SEARCH)
    else $error("compare without a preceding table read");

  // Line count stays within the table
  assert property (@(posedge clk) disable iff (rst)
    lines_recorded >= LINE_W'(1) && lines_recorded <= LINE_W'(MAX_LINES))
    else $error("line count out of range");

  // No table write once the table is full
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> lines_recorded < LINE_W'(MAX_LINES))
    else $error("table write past the end");

  // A completed search reports a line within the recorded range
  assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK |-> line <= lines_recorded && line != '0)
    else $error("search result outside the table");

  // Search window never inverts
  assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> lo < hi)
    else $error("search window collapsed");

endmodule

`default_nettype wire
